FILE: hw/rtl/life_grid_generation_step_assert.svh
// Assertion macros for the life grid generation step block.
// Included by the top level; no other dependencies.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define LGS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LGS_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGS_ASSERT_RST(label, clk, rst, prop, msg)
`define LGS_ASSERT(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/lgs_pkg.sv
// Package for the life grid generation step block: request codes, rule
// constants, controller state type and grid defaults. No dependencies.
package lgs_pkg;

   // Request codes carried in tuser
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Field widths
   localparam int unsigned REQ_TYPE_W  = 2;
   localparam int unsigned CELL_IDX_W  = 6;
   localparam int unsigned GRID_SIZE_W = 7;

   // Grid defaults
   localparam int unsigned GRID_MAX_DEFAULT = 64;
   localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

   // Rule B3/S23 neighbor counts
   localparam logic [3:0] LIVE_STAY  = 4'd2;
   localparam logic [3:0] LIVE_BIRTH = 4'd3;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_GEN,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/life_grid_generation_step.sv
// Life grid, rule B3/S23: rows of cells in one synchronous RAM, one row word per entry.
// A cell read or write passes the cell state, then the done state; a generation over
// active size n reads one row and writes one row per cycle; an access out of range, the
// unused code or a step at size zero goes straight to done. A request is taken only
// while idle, and a result still waiting in the output register holds the next accept.
// Reset (synchronous) clears every row through per-row valid bits and sets the size to 64.
module life_grid_generation_step #(
   parameter int unsigned GRID_MAX = lgs_pkg::GRID_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // row[5:0], col[11:6], alive_in[12], zero[15:13]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Response item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // cell_alive[0], zero[7:1]
   output logic [0:0]  rsp_tuser,   // status[0]
   // Grid size register
   input  logic        csr_wr_en,
   input  logic [lgs_pkg::GRID_SIZE_W-1:0] csr_wr_data
);
   import lgs_pkg::*;

   localparam int unsigned RW   = $clog2(GRID_MAX);
   localparam int unsigned SZ_W = $clog2(GRID_MAX + 1);
   localparam int unsigned CW   = ((SZ_W > GRID_SIZE_W) ? SZ_W : GRID_SIZE_W) + 1;

   // Request fields
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CELL_IDX_W-1:0] req_row;
   logic [CELL_IDX_W-1:0] req_col;
   logic                  req_alive;
   logic                  req_fire;

   assign req_type  = req_tuser;
   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[11:6];
   assign req_alive = req_tdata[12];

   // Registers
   state_type             state_ff, state_in;
   logic [GRID_SIZE_W-1:0] grid_size_ff;
   logic [GRID_MAX-1:0]   cell_mem [GRID_MAX];
   logic [GRID_MAX-1:0]   row_valid_ff;
   logic [GRID_MAX-1:0]   rd_data_ff;
   logic                  rd_valid_ff;
   logic [GRID_MAX-1:0]   prior_ff;
   logic [GRID_MAX-1:0]   cur_ff;
   logic [SZ_W-1:0]       cnt_ff;
   logic [REQ_TYPE_W-1:0] op_ff;
   logic [RW-1:0]         col_ff;
   logic                  alive_ff;
   logic [RW-1:0]         addr_ff;
   logic                  res_alive_ff;
   logic                  res_status_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_alive_ff;
   logic                  rsp_status_ff;

   // Active size: register clamped to the grid depth
   logic [CW-1:0]   size_wide;
   logic [SZ_W-1:0] act_size;
   logic [CW-1:0]   act_wide;

   assign size_wide = CW'(grid_size_ff);
   assign act_wide  = (size_wide > CW'(GRID_MAX)) ? CW'(GRID_MAX) : size_wide;
   assign act_size  = act_wide[SZ_W-1:0];

   // Range check and row/column indexes of the request
   logic            req_oor;
   logic [RW+5:0]   row_wide;
   logic [RW+5:0]   col_wide;

   assign req_oor  = (CW'(req_row) >= act_wide) || (CW'(req_col) >= act_wide);
   assign row_wide = (RW + 6)'(req_row);
   assign col_wide = (RW + 6)'(req_col);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Row just read; a row never written since reset reads as dead
   logic [GRID_MAX-1:0] rd_row;
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

   // Sweep counters
   logic            gen_last;
   logic [SZ_W-1:0] cnt_p1;
   logic [SZ_W-1:0] cnt_m1;
   logic [CW-1:0]   cnt_p1_wide;

   assign gen_last    = (cnt_ff == act_size);
   assign cnt_p1      = cnt_ff + SZ_W'(1);
   assign cnt_m1      = cnt_ff - SZ_W'(1);
   assign cnt_p1_wide = CW'(cnt_p1);

   // Active column mask
   logic [GRID_MAX-1:0] col_mask;
   for (genvar c = 0; c < GRID_MAX; c++) begin : g_mask
      assign col_mask[c] = (CW'(c) < act_wide);
   end

   // Next generation of row cnt-1 from rows above, itself and below
   logic [GRID_MAX-1:0] nxt_row;
   logic [GRID_MAX-1:0] up_m, mid_m, dn_m;
   logic [GRID_MAX-1:0] gen_row;

   assign nxt_row = gen_last ? '0 : rd_row;
   assign up_m    = prior_ff & col_mask;
   assign mid_m   = cur_ff & col_mask;
   assign dn_m    = nxt_row & col_mask;

   for (genvar c = 0; c < GRID_MAX; c++) begin : g_cell
      logic l_up, l_mid, l_dn, r_up, r_mid, r_dn;
      logic [3:0] live;
      if (c > 0) begin : g_left
         assign l_up  = up_m[c-1];
         assign l_mid = mid_m[c-1];
         assign l_dn  = dn_m[c-1];
      end else begin : g_left_edge
         assign l_up  = 1'b0;
         assign l_mid = 1'b0;
         assign l_dn  = 1'b0;
      end
      if (c < GRID_MAX - 1) begin : g_right
         assign r_up  = up_m[c+1];
         assign r_mid = mid_m[c+1];
         assign r_dn  = dn_m[c+1];
      end else begin : g_right_edge
         assign r_up  = 1'b0;
         assign r_mid = 1'b0;
         assign r_dn  = 1'b0;
      end
      assign live = 4'(l_up) + 4'(up_m[c]) + 4'(r_up) + 4'(l_mid) + 4'(r_mid)
                  + 4'(l_dn) + 4'(dn_m[c]) + 4'(r_dn);
      // Cells outside the active grid keep their value
      assign gen_row[c] = !col_mask[c] ? cur_ff[c] :
                          cur_ff[c] ? ((live == LIVE_STAY) || (live == LIVE_BIRTH)) :
                                      (live == LIVE_BIRTH);
   end

   // Cell update for a single write
   logic [GRID_MAX-1:0] cell_row;
   always_comb begin
      cell_row         = rd_row;
      cell_row[col_ff] = alive_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_type == REQ_STEP && act_size != '0) begin
                  state_in = ST_GEN;
               end else if ((req_type == REQ_WRITE || req_type == REQ_READ) && !req_oor) begin
                  state_in = ST_CELL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CELL: state_in = ST_DONE;
         ST_GEN: begin
            if (gen_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory port controls
   logic                mem_we;
   logic [RW-1:0]       wr_addr;
   logic [GRID_MAX-1:0] wr_data;
   logic [RW-1:0]       rd_addr;

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = addr_ff;
      wr_data = cell_row;
      rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_type == REQ_STEP) begin
               rd_addr = '0;
            end else if (!req_oor) begin
               rd_addr = row_wide[RW-1:0];
            end
         end
         ST_CELL: begin
            mem_we = (op_ff == REQ_WRITE);
         end
         ST_GEN: begin
            mem_we  = (cnt_ff != '0);
            wr_addr = cnt_m1[RW-1:0];
            wr_data = gen_row;
            if (cnt_p1_wide < act_wide) begin
               rd_addr = cnt_p1[RW-1:0];
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // Row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= cell_mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_size_ff <= GRID_SIZE_RESET;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= row_valid_ff[rd_addr];
         if (csr_wr_en) begin
            grid_size_ff <= csr_wr_data;
         end
         if (mem_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         // Load the pending response, else drop a taken one
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      // Capture the request
      if (req_fire) begin
         op_ff         <= req_type;
         col_ff        <= col_wide[RW-1:0];
         alive_ff      <= req_alive;
         addr_ff       <= row_wide[RW-1:0];
         prior_ff      <= '0;
         cur_ff        <= '0;
         cnt_ff        <= '0;
         res_alive_ff  <= 1'b0;
         res_status_ff <= (req_type == REQ_WRITE || req_type == REQ_READ) && req_oor;
      end
      // Pick the read cell
      if (state_ff == ST_CELL && op_ff == REQ_READ) begin
         res_alive_ff <= rd_row[col_ff];
      end
      // Advance the row window
      if (state_ff == ST_GEN) begin
         prior_ff <= cur_ff;
         cur_ff   <= rd_row;
         cnt_ff   <= cnt_p1;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_alive_ff  <= res_alive_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {7'b0, rsp_alive_ff};
   assign rsp_tuser[0] = rsp_status_ff;

   // Checks
`include "life_grid_generation_step_assert.svh"

   `LGS_ASSERT_RST(a_we_state, clock, reset,
      mem_we |-> (state_ff == ST_GEN || state_ff == ST_CELL),
      "row write outside cell or sweep state")
   `LGS_ASSERT_RST(a_step_sweep, clock, reset,
      (req_fire && req_type == REQ_STEP && act_size != '0) |=> (state_ff == ST_GEN),
      "step did not start a sweep")
   `LGS_ASSERT_RST(a_cnt_range, clock, reset,
      (state_ff == ST_GEN) |-> (cnt_ff <= act_size),
      "sweep counter past active size")
   `LGS_ASSERT_RST(a_done_load, clock, reset,
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff,
      "pending result not loaded")
   `LGS_ASSERT(a_reset_idle, clock,
      reset |=> (state_ff == ST_IDLE && !rsp_valid_ff),
      "reset left controller busy")

endmodule
